// ===== src/plid_pkg.sv =====
// Shared constants and types for the positional list block.
`timescale 1ns / 1ps

package plid_pkg;

	localparam int CAPACITY_DEF   = 32;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int POS_W   = 6;
	localparam int VAL_W   = 32;
	localparam int REQ_W   = 2;
	localparam int COUNT_W = 6;
	localparam int CMP_W   = 8;

	localparam logic [REQ_W-1:0] REQ_GET    = 2'd0;
	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
	localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	// broadcast to every cell in the accepting cycle
	typedef struct packed {
		logic             ins;
		logic             del;
		logic [POS_W-1:0] idx;
	} cell_ctrl_t;

endpackage

// ===== src/positional_list_insert_delete.sv =====
// Top level of the bounded positional list: request decode, cell row, result register.
`timescale 1ns / 1ps

// Usage:
//   Requests arrive on the s_ group: s_tuser carries the request kind
//   (get, insert, delete, clear), s_tdata the position and the value.
//   Every request yields exactly one result on the m_ group: m_tuser is the
//   error flag, m_tdata the read or removed element and the new length.
//   The list lives in a row of CAPACITY cells; an insert or delete moves every
//   later cell by one place in the cycle of the transfer, a get reads the
//   addressed cell in that same cycle.
//   The result is registered: it sits in the output register on the edge
//   after the request transfer. Throughput is one request per cycle while
//   s_tready is high, set by the update of the cell row in the transfer cycle.
//   While m_tready is low the result register holds its item; s_tready stays
//   high as long as that register is empty or is being emptied in the cycle.
//   Reset empties the list and the output register; cell contents are left
//   as they are and are never read before they are written.
module positional_list_insert_delete #(
	parameter int CAPACITY   = plid_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = plid_pkg::DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [5:0] position, [37:6] value, [39:38] zero
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] value_out, [37:32] count, [39:38] zero
	output logic        m_tuser    // [0] status
);
	import plid_pkg::*;

	localparam int FILL_W = $clog2(CAPACITY + 1);

	logic [FILL_W-1:0]     fill_q;
	logic                  out_valid_q;
	logic                  status_q;
	logic [VAL_W-1:0]      value_out_q;
	logic [COUNT_W-1:0]    count_q;

	logic                  take;
	logic [REQ_W-1:0]      req;
	logic [POS_W-1:0]      pos;
	logic [CMP_W-1:0]      pos_c;
	logic [CMP_W-1:0]      fill_c;
	logic                  pos_ok;
	logic                  ins_ok;
	logic                  err;
	logic [FILL_W-1:0]     fill_nxt;
	logic [DATA_WIDTH-1:0] new_val;
	logic [DATA_WIDTH-1:0] rd_data;
	cell_ctrl_t            ctrl;

	logic [DATA_WIDTH-1:0] cell_val [CAPACITY];
	logic [DATA_WIDTH-1:0] cell_rd  [CAPACITY];

	assign s_tready = !out_valid_q || m_tready;
	assign take     = s_tvalid && s_tready;
	assign req      = s_tuser;
	assign pos      = s_tdata[POS_W-1:0];
	assign new_val  = DATA_WIDTH'(s_tdata[POS_W +: VAL_W]);

	assign pos_c  = CMP_W'(pos);
	assign fill_c = CMP_W'(fill_q);
	assign pos_ok = (pos != '0) && (pos_c <= fill_c);
	assign ins_ok = (fill_c < CMP_W'(CAPACITY)) && (pos != '0) &&
	                (pos_c <= fill_c + CMP_W'(1));

	always_comb begin
		err      = 1'b0;
		fill_nxt = fill_q;
		ctrl.ins = 1'b0;
		ctrl.del = 1'b0;
		ctrl.idx = pos - POS_W'(1);
		unique case (req)
			REQ_GET: begin
				err = !pos_ok;
			end
			REQ_INSERT: begin
				err      = !ins_ok;
				ctrl.ins = take && ins_ok;
				if (ins_ok)
					fill_nxt = fill_q + FILL_W'(1);
			end
			REQ_DELETE: begin
				err      = !pos_ok;
				ctrl.del = take && pos_ok;
				if (pos_ok)
					fill_nxt = fill_q - FILL_W'(1);
			end
			REQ_CLEAR: begin
				fill_nxt = '0;
			end
			default: begin
				err = 1'b0;
			end
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] prev_v;
		logic [DATA_WIDTH-1:0] next_v;
		if (i == 0) begin : g_first
			assign prev_v = new_val;
		end else begin : g_mid
			assign prev_v = cell_val[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign next_v = cell_val[i];
		end else begin : g_inner
			assign next_v = cell_val[i+1];
		end
		plid_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.IDX        (POS_W'(i))
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.new_val  (new_val),
			.prev_val (prev_v),
			.next_val (next_v),
			.val      (cell_val[i]),
			.rd_val   (cell_rd[i])
		);
	end

	always_comb begin
		rd_data = '0;
		for (int i = 0; i < CAPACITY; i++)
			rd_data = rd_data | cell_rd[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				fill_q      <= fill_nxt;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status_q    <= err ? STATUS_ERR : STATUS_OK;
			count_q     <= COUNT_W'(fill_nxt);
			value_out_q <= (!err && (req == REQ_GET || req == REQ_DELETE)) ?
			               VAL_W'(rd_data) : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {2'b00, count_q, value_out_q};

endmodule

// ===== src/plid_cell.sv =====
// One storage cell of the list; shifts toward either neighbor.
`timescale 1ns / 1ps

module plid_cell #(
	parameter int                 DATA_WIDTH = plid_pkg::DATA_WIDTH_DEF,
	parameter logic [plid_pkg::POS_W-1:0] IDX = '0
) (
	input  logic                   clk,
	input  plid_pkg::cell_ctrl_t   ctrl,
	input  logic [DATA_WIDTH-1:0]  new_val,
	input  logic [DATA_WIDTH-1:0]  prev_val,
	input  logic [DATA_WIDTH-1:0]  next_val,
	output logic [DATA_WIDTH-1:0]  val,
	output logic [DATA_WIDTH-1:0]  rd_val
);
	import plid_pkg::*;

	logic [DATA_WIDTH-1:0] entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (IDX == ctrl.idx)
				entry_q <= new_val;
			else if (IDX > ctrl.idx)
				entry_q <= prev_val;
		end else if (ctrl.del && IDX >= ctrl.idx) begin
			entry_q <= next_val;
		end
	end

	assign val    = entry_q;
	assign rd_val = (IDX == ctrl.idx) ? entry_q : '0;

endmodule

// ===== verif/positional_list_checker.sv =====
// Checker for the positional list: predicts every request's result and compares each result transfer.
`timescale 1ns / 1ps

module positional_list_checker #(
	parameter int CAPACITY = plid_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,   // [5:0] position, [37:6] value, [39:38] zero
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,   // [31:0] value_out, [37:32] count, [39:38] zero
	input  logic        m_tuser,   // [0] status
	output int          fail_count,
	output int          outstanding,
	output int          results_checked,
	output int          error_results,
	output int          peak_length
);
	import plid_pkg::*;

	typedef struct packed {
		logic               status;
		logic [VAL_W-1:0]   value_out;
		logic [COUNT_W-1:0] count;
	} list_result_t;

	logic [VAL_W-1:0] shadow_entries [CAPACITY];
	int               shadow_len;
	list_result_t     expected_results [$];

	initial begin
		fail_count      = 0;
		outstanding     = 0;
		results_checked = 0;
		error_results   = 0;
		peak_length     = 0;
		shadow_len      = 0;
	end

	function automatic list_result_t apply_request(logic [REQ_W-1:0] kind,
			logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
		list_result_t r;
		int           p;
		int           j;
		r        = '0;
		r.status = STATUS_OK;
		p        = pos;
		case (kind)
			REQ_GET: begin
				if (p < 1 || p > shadow_len)
					r.status = STATUS_ERR;
				else
					r.value_out = shadow_entries[p-1];
			end
			REQ_INSERT: begin
				if (shadow_len >= CAPACITY || p < 1 || p > shadow_len + 1) begin
					r.status = STATUS_ERR;
				end else begin
					for (j = shadow_len; j > p - 1; j--)
						shadow_entries[j] = shadow_entries[j-1];
					shadow_entries[p-1] = val;
					shadow_len++;
				end
			end
			REQ_DELETE: begin
				if (shadow_len < 1 || p < 1 || p > shadow_len) begin
					r.status = STATUS_ERR;
				end else begin
					r.value_out = shadow_entries[p-1];
					for (j = p - 1; j + 1 < shadow_len; j++)
						shadow_entries[j] = shadow_entries[j+1];
					shadow_len--;
				end
			end
			default: begin
				shadow_len = 0;
			end
		endcase
		r.count = shadow_len[COUNT_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("%0t: mismatch on %s: got %0h, expected %0h", $time, field, got, want);
		fail_count++;
	endtask

	always @(posedge clk) begin
		list_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with no request pending",
						64'({m_tuser, m_tdata}), '0);
				end else begin
					want = expected_results.pop_front();
					outstanding--;
					results_checked++;
					if (want.status == STATUS_ERR)
						error_results++;
					if (m_tuser !== want.status)
						report_mismatch("status", 64'(m_tuser), 64'(want.status));
					if (m_tdata[31:0] !== want.value_out)
						report_mismatch("value_out", 64'(m_tdata[31:0]),
							64'(want.value_out));
					if (m_tdata[37:32] !== want.count)
						report_mismatch("count", 64'(m_tdata[37:32]), 64'(want.count));
					if (m_tdata[39:38] !== 2'b00)
						report_mismatch("tdata padding", 64'(m_tdata[39:38]), '0);
				end
			end
			if (s_tvalid && s_tready) begin
				expected_results.push_back(apply_request(s_tuser, s_tdata[5:0], s_tdata[37:6]));
				outstanding++;
				if (shadow_len > peak_length)
					peak_length = shadow_len;
			end
		end
	end

endmodule

// ===== verif/positional_list_insert_delete_test.sv =====
// Testbench top for the positional list: clock, reset, request stimulus, result back-pressure, verdict.
`timescale 1ns / 1ps

module positional_list_insert_delete_test;
	import plid_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 930;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [39:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        m_tready = 1'b0;
	logic        s_tready;
	logic        m_tvalid;
	logic [39:0] m_tdata;
	logic        m_tuser;

	int fail_count;
	int outstanding;
	int results_checked;
	int error_results;
	int peak_length;
	int cycle_count   = 0;
	int requests_sent = 0;
	int list_len      = 0;
	bit send_burst    = 1'b0;
	bit recv_burst    = 1'b0;

	positional_list_insert_delete dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	positional_list_checker #(.CAPACITY(CAPACITY_DEF)) list_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.fail_count      (fail_count),
		.outstanding     (outstanding),
		.results_checked (results_checked),
		.error_results   (error_results),
		.peak_length     (peak_length)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timeout after %0d cycles", cycle_count);
		$display("Verification failed");
		$finish;
	end

	// length of the list as the stimulus sees it, used to aim positions
	function automatic int track_length(logic [REQ_W-1:0] kind, logic [POS_W-1:0] pos, int len);
		case (kind)
			REQ_INSERT: return (len < CAPACITY_DEF && pos >= 1 && pos <= len + 1) ? len + 1 : len;
			REQ_DELETE: return (pos >= 1 && pos <= len) ? len - 1 : len;
			REQ_CLEAR:  return 0;
			default:    return len;
		endcase
	endfunction

	task automatic send_request(logic [REQ_W-1:0] kind, logic [POS_W-1:0] pos,
			logic [VAL_W-1:0] val);
		int gap;
		if ($urandom_range(0, 63) == 0)
			send_burst = !send_burst;
		gap = send_burst ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tuser  <= kind;
		s_tdata  <= {2'b00, val, pos};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!(s_tvalid && s_tready));
		list_len = track_length(kind, pos, list_len);
		requests_sent++;
	endtask

	task automatic send_random(bit grow);
		logic [REQ_W-1:0] kind;
		int               pos;
		int               roll;
		roll = $urandom_range(0, 99);
		if (roll < 2)
			kind = REQ_CLEAR;
		else if (roll < (grow ? 62 : 22))
			kind = REQ_INSERT;
		else if (roll < (grow ? 77 : 80))
			kind = REQ_DELETE;
		else
			kind = REQ_GET;
		if ($urandom_range(0, 99) < 12)
			pos = $urandom_range(0, 63);
		else if (kind == REQ_INSERT)
			pos = $urandom_range(1, list_len + 1);
		else if (list_len > 0)
			pos = $urandom_range(1, list_len);
		else
			pos = $urandom_range(0, 2);
		send_request(kind, pos[POS_W-1:0], $urandom);
	endtask

	// result side: random stall before each transfer, with stall-free stretches
	initial begin
		int stall;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 63) == 0)
				recv_burst = !recv_burst;
			stall = recv_burst ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	initial begin
		bit grow;
		int phase_left;
		int i;
		grow       = 1'b1;
		phase_left = $urandom_range(40, 120);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list and bad positions
		send_request(REQ_GET,    6'd1,  32'h0000_0000);
		send_request(REQ_DELETE, 6'd1,  32'hffff_ffff);
		send_request(REQ_INSERT, 6'd0,  32'h1234_5678);
		send_request(REQ_INSERT, 6'd2,  32'h8765_4321);
		// build a short list: front, front, append, middle
		send_request(REQ_INSERT, 6'd1,  32'h8000_0000);
		send_request(REQ_INSERT, 6'd1,  32'h7fff_ffff);
		send_request(REQ_INSERT, 6'd3,  32'hffff_ffff);
		send_request(REQ_INSERT, 6'd2,  32'h0000_0000);
		send_request(REQ_INSERT, 6'd63, 32'haaaa_5555);
		send_request(REQ_GET,    6'd0,  32'h0000_0000);
		send_request(REQ_GET,    6'd1,  32'h0000_0000);
		send_request(REQ_GET,    6'd4,  32'h0000_0000);
		send_request(REQ_GET,    6'd5,  32'h0000_0000);
		send_request(REQ_GET,    6'd63, 32'h0000_0000);
		send_request(REQ_DELETE, 6'd0,  32'h0000_0000);
		send_request(REQ_DELETE, 6'd63, 32'h0000_0000);
		send_request(REQ_DELETE, 6'd2,  32'h0000_0000);
		send_request(REQ_DELETE, 6'd3,  32'h0000_0000);
		send_request(REQ_GET,    6'd2,  32'h0000_0000);
		// clear keeps cell contents but empties the list
		send_request(REQ_CLEAR,  6'd0,  32'hffff_ffff);
		send_request(REQ_GET,    6'd1,  32'h0000_0000);
		send_request(REQ_DELETE, 6'd1,  32'h0000_0000);
		send_request(REQ_CLEAR,  6'd63, 32'h0000_0000);
		send_request(REQ_INSERT, 6'd1,  32'h5a5a_a5a5);
		send_request(REQ_GET,    6'd1,  32'h0000_0000);

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (phase_left == 0) begin
				grow       = !grow;
				phase_left = $urandom_range(40, 120);
			end
			phase_left--;
			send_random(grow);
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (4) @(posedge clk);

		$display("Sent %0d requests, checked %0d results, %0d of them error results.",
			requests_sent, results_checked, error_results);
		$display("Longest list reached %0d of %0d entries.", peak_length, CAPACITY_DEF);
		if (fail_count == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
